### src/fprb_pkg.sv
// Shared types, constants and helpers for the feathered raw pixel blend.
`default_nettype none
package fprb_pkg;

    // Window clamp and fixed-point constants
    localparam logic [13:0] MAX_DIM    = 14'd8192;
    localparam logic [17:0] UNITY      = 18'h10000;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Ramp divider: 17 quotient bits, one per stage
    localparam int DIV_STEPS  = 17;

    // Register indexes
    typedef enum logic [7:0] {
        REG_USABLE_WIDTH    = 8'd0,
        REG_USABLE_HEIGHT   = 8'd1,
        REG_FEATHER_LEFT    = 8'd2,
        REG_FEATHER_RIGHT   = 8'd3,
        REG_FEATHER_BOTTOM  = 8'd4,
        REG_FEATHER_TOP     = 8'd5,
        REG_BLACK_OFFSET    = 8'd6,
        REG_GAIN            = 8'd7
    } reg_index_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic        command;
        logic        in_window;
        logic [15:0] s;
        logic [31:0] canvas;
        logic [13:0] hn;
        logic [13:0] hd;
        logic [13:0] vn;
        logic [13:0] vd;
    } item_t;

    // Partial state of one restoring division
    typedef struct packed {
        logic [14:0] r;
        logic [13:0] d;
        logic [16:0] q;
    } div_t;

    // Payload of one divider stage
    typedef struct packed {
        logic        command;
        logic        in_window;
        logic        sat;
        logic [31:0] scaled;
        logic [31:0] canvas;
        div_t        h;
        div_t        v;
    } dstage_t;

    // One quotient bit of (n * 2^16) / d
    function automatic div_t div_step(input div_t x);
        div_t        y;
        logic        ge;
        logic [14:0] diff;
        logic [14:0] nr;
        ge   = x.r >= {1'b0, x.d};
        diff = x.r - {1'b0, x.d};
        nr   = ge ? diff : x.r;
        y.r  = {nr[13:0], 1'b0};
        y.d  = x.d;
        y.q  = {x.q[15:0], ge};
        return y;
    endfunction

endpackage
`default_nettype wire

### src/fprb_front.sv
// Front part: configuration registers, window test and ramp operand selection.
`default_nettype none
module fprb_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 command,
    input  wire logic [12:0]          col,
    input  wire logic [12:0]          row,
    input  wire logic [15:0]          sample,
    input  wire logic [31:0]          canvas_in,
    output fprb_pkg::item_t           item,
    output logic [31:0]               gain
);
    import fprb_pkg::*;

    logic [13:0] uw_reg, uh_reg, fl_reg, fr_reg, fb_reg, ft_reg;
    logic [15:0] black_reg;
    logic [31:0] gain_reg;
    logic [13:0] w, h, col_x, row_x, wdist, hdist;

    assign cfg_ready = 1'b1;
    assign gain      = gain_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uw_reg    <= MAX_DIM;
            uh_reg    <= MAX_DIM;
            fl_reg    <= '0;
            fr_reg    <= '0;
            fb_reg    <= '0;
            ft_reg    <= '0;
            black_reg <= '0;
            gain_reg  <= 32'd4194304;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_USABLE_WIDTH:   uw_reg    <= cfg_data[13:0];
                REG_USABLE_HEIGHT:  uh_reg    <= cfg_data[13:0];
                REG_FEATHER_LEFT:   fl_reg    <= cfg_data[13:0];
                REG_FEATHER_RIGHT:  fr_reg    <= cfg_data[13:0];
                REG_FEATHER_BOTTOM: fb_reg    <= cfg_data[13:0];
                REG_FEATHER_TOP:    ft_reg    <= cfg_data[13:0];
                REG_BLACK_OFFSET:   black_reg <= cfg_data[15:0];
                REG_GAIN:           gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify: window test, black level, ramp numerator and divisor
    always_comb begin
        w     = (uw_reg > MAX_DIM) ? MAX_DIM : uw_reg;
        h     = (uh_reg > MAX_DIM) ? MAX_DIM : uh_reg;
        col_x = {1'b0, col};
        row_x = {1'b0, row};
        wdist = w - col_x;
        hdist = h - row_x;

        item.command   = command;
        item.canvas    = canvas_in;
        item.in_window = (col_x < w) && (row_x < h);
        item.s         = (sample > black_reg) ? sample - black_reg : 16'd0;

        // left ramp wins over right; no ramp divides 1 by 1 for unity
        if (fl_reg != '0 && col_x < fl_reg) begin
            item.hn = col_x;
            item.hd = fl_reg;
        end else if (fr_reg != '0 && wdist <= fr_reg) begin
            item.hn = wdist;
            item.hd = fr_reg;
        end else begin
            item.hn = 14'd1;
            item.hd = 14'd1;
        end

        if (fb_reg != '0 && row_x < fb_reg) begin
            item.vn = row_x;
            item.vd = fb_reg;
        end else if (ft_reg != '0 && hdist <= ft_reg) begin
            item.vn = hdist;
            item.vd = ft_reg;
        end else begin
            item.vn = 14'd1;
            item.vd = 14'd1;
        end
    end

endmodule
`default_nettype wire

### src/fprb_fifo.sv
// Short queue of classified items between front and back.
`default_nettype none
module fprb_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire fprb_pkg::item_t wr_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output fprb_pkg::item_t      rd_item
);
    import fprb_pkg::*;

    item_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_item   = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH)) else $error("queue count overflow");
    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");
    a_cnt_down: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

### src/fprb_back.sv
// Back part: scale, ramp dividers, weight and blend pipeline with output register.
`default_nettype none
module fprb_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            head_valid,
    input  wire fprb_pkg::item_t head,
    input  wire logic [31:0]     gain,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [31:0]          out_canvas,
    output logic                 out_in_window,
    output logic                 out_sat
);
    import fprb_pkg::*;

    dstage_t     st_reg  [DIV_STEPS+1];
    logic        vld_reg [DIV_STEPS+1];
    dstage_t     ld;
    logic [47:0] prod0;
    logic [39:0] shifted;
    logic        adv;

    // stage A: weight
    logic        a_vld_reg, a_cmd_reg, a_win_reg, a_sat_reg;
    logic [31:0] a_scaled_reg, a_canvas_reg;
    logic [16:0] a_wt_reg;
    logic [33:0] wprod;
    // stage B: blend products
    logic        b_vld_reg, b_cmd_reg, b_win_reg, b_sat_reg;
    logic [31:0] b_scaled_reg, b_canvas_reg;
    logic [48:0] b_p1_reg, b_p2_reg;
    logic [16:0] inv_wt;
    // output register
    logic        o_vld_reg, o_win_reg, o_sat_reg;
    logic [31:0] o_data_reg;
    logic [49:0] bsum;
    logic [31:0] diff, result;

    assign adv = !o_vld_reg || out_ready;
    assign pop = adv && head_valid;

    // Load stage: scale by gain, saturate, seed the dividers
    always_comb begin
        prod0        = {32'd0, head.s} * {16'd0, gain};
        shifted      = prod0[47:8];
        ld.command   = head.command;
        ld.in_window = head.in_window;
        ld.canvas    = head.canvas;
        ld.sat       = |shifted[39:32];
        ld.scaled    = ld.sat ? 32'hFFFF_FFFF : shifted[31:0];
        ld.h.r       = {1'b0, head.hn};
        ld.h.d       = head.hd;
        ld.h.q       = '0;
        ld.v.r       = {1'b0, head.vn};
        ld.v.d       = head.vd;
        ld.v.q       = '0;
    end

    // Divider stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= ld;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                st_reg[k].command   <= st_reg[k-1].command;
                st_reg[k].in_window <= st_reg[k-1].in_window;
                st_reg[k].sat       <= st_reg[k-1].sat;
                st_reg[k].scaled    <= st_reg[k-1].scaled;
                st_reg[k].canvas    <= st_reg[k-1].canvas;
                st_reg[k].h         <= div_step(st_reg[k-1].h);
                st_reg[k].v         <= div_step(st_reg[k-1].v);
            end
        end
    end

    // Weight, products, final select
    always_comb begin
        wprod  = {17'd0, st_reg[DIV_STEPS].h.q} * {17'd0, st_reg[DIV_STEPS].v.q};
        inv_wt = 17'(UNITY - {1'b0, a_wt_reg});
        bsum   = {1'b0, b_p1_reg} + {1'b0, b_p2_reg};
        diff   = (b_canvas_reg >= b_scaled_reg) ? b_canvas_reg - b_scaled_reg
                                                : b_scaled_reg - b_canvas_reg;
        if (!b_win_reg)     result = b_canvas_reg;
        else if (b_cmd_reg) result = diff;
        else                result = bsum[47:16];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_cmd_reg    <= st_reg[DIV_STEPS].command;
            a_win_reg    <= st_reg[DIV_STEPS].in_window;
            a_sat_reg    <= st_reg[DIV_STEPS].sat;
            a_scaled_reg <= st_reg[DIV_STEPS].scaled;
            a_canvas_reg <= st_reg[DIV_STEPS].canvas;
            a_wt_reg     <= wprod[32:16];

            b_cmd_reg    <= a_cmd_reg;
            b_win_reg    <= a_win_reg;
            b_sat_reg    <= a_sat_reg;
            b_scaled_reg <= a_scaled_reg;
            b_canvas_reg <= a_canvas_reg;
            b_p1_reg     <= {17'd0, a_scaled_reg} * {32'd0, a_wt_reg};
            b_p2_reg     <= {17'd0, a_canvas_reg} * {32'd0, inv_wt};

            o_data_reg   <= result;
            o_win_reg    <= b_win_reg;
            o_sat_reg    <= b_win_reg && b_sat_reg;
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) vld_reg[k] <= 1'b0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= head_valid;
            for (int k = 1; k <= DIV_STEPS; k++) vld_reg[k] <= vld_reg[k-1];
            a_vld_reg <= vld_reg[DIV_STEPS];
            b_vld_reg <= a_vld_reg;
            o_vld_reg <= b_vld_reg;
        end
    end

    assign out_valid     = o_vld_reg;
    assign out_canvas    = o_data_reg;
    assign out_in_window = o_win_reg;
    assign out_sat       = o_sat_reg;

`ifndef NO_ASSERTIONS
    a_sat_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        o_vld_reg && !o_win_reg |-> !o_sat_reg)
        else $error("saturation flagged outside window");
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STEPS] && st_reg[DIV_STEPS].in_window |->
        st_reg[DIV_STEPS].h.q <= 17'h10000 && st_reg[DIV_STEPS].v.q <= 17'h10000)
        else $error("ramp weight above unity");
    a_wt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        a_vld_reg && a_win_reg |-> a_wt_reg <= 17'h10000)
        else $error("feather weight above unity");
`endif

endmodule
`default_nettype wire

### src/feathered_raw_pixel_blend.sv
// Top level of the feathered raw pixel blend: front, queue and back.
//
// Usage: one pixel per s_ transaction (command in s_tuser, position, raw
// sample and canvas value in s_tdata); one result per m_ transaction
// (new canvas value in m_tdata, in_window and saturated in m_tuser).
// Registers are written over cfg_, one per transaction, by the user only while
// the block is idle (not enforced by the block); cfg_ready is always high.
// Throughput: one pixel per cycle while m_tready is high, set by the fully
// pipelined back end. With an empty queue an accepted pixel reaches m_tvalid
// through the gain scaling stage loaded from the queue head, 17 ramp
// divider stages (one quotient bit each, horizontal and vertical in
// parallel), the weight multiply, the blend multiplies and output register.
// When m_tvalid is high and m_tready low the back pipeline holds; the queue
// (four entries) keeps taking pixels until full, then s_tready drops.
// Reset (aresetn low, synchronous) empties queue and pipeline and loads
// the register defaults: full 8192 window, no feather, no black level,
// gain 4194304.
`default_nettype none
module feathered_raw_pixel_blend (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // col[12:0], row[25:13], sample[41:26],
                                        // canvas_in[73:42], zero pad
    input  wire logic [0:0]  s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // canvas_out[31:0]
    output logic [1:0]       m_tuser,   // in_window[0], saturated[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import fprb_pkg::*;

    item_t       fr_item, head;
    logic [31:0] gain;
    logic        full, not_empty, pop;
    logic        out_win, out_sat;

    fprb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (s_tuser[0]),
        .col       (s_tdata[12:0]),
        .row       (s_tdata[25:13]),
        .sample    (s_tdata[41:26]),
        .canvas_in (s_tdata[73:42]),
        .item      (fr_item),
        .gain      (gain)
    );

    assign s_tready = !full;

    fprb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .wr_item   (fr_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_item   (head)
    );

    fprb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (not_empty),
        .head          (head),
        .gain          (gain),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_canvas    (m_tdata),
        .out_in_window (out_win),
        .out_sat       (out_sat)
    );

    assign m_tuser = {out_sat, out_win};

endmodule
`default_nettype wire
